// ===== rtl/core/fpst_pkg.sv =====
package fpst_pkg;

   // default table depth
   localparam int FLOW_SLOTS_DEFAULT = 64;

   // field widths
   localparam int ADDR_W    = 32;
   localparam int LEN_W     = 16;
   localparam int TTL_W     = 8;
   localparam int PROTO_W   = 8;
   localparam int PORT_W    = 16;
   localparam int SLOT_W    = 6;
   localparam int OUTCOME_W = 2;
   localparam int PKT_SUM_W = 32;
   localparam int LEN_SUM_W = 48;
   localparam int TTL_SUM_W = 40;
   localparam int PRT_SUM_W = 48;

   // stream widths
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 224;
   localparam int RSP_USER_W = OUTCOME_W;

   localparam logic [PROTO_W-1:0] TCP_PROTOCOL = 8'd6;

   // outcome codes
   localparam logic [OUTCOME_W-1:0] OUTCOME_NEW   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_OTHER = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FULL  = 2'd3;

   // one packet header walking down the cell chain, plus its result once resolved
   typedef struct packed {
      logic                 done;
      logic [SLOT_W-1:0]    slot_index;
      logic [OUTCOME_W-1:0] outcome;
      logic [ADDR_W-1:0]    source_address;
      logic [ADDR_W-1:0]    dest_address;
      logic [LEN_W-1:0]     total_length;
      logic [TTL_W-1:0]     time_to_live;
      logic [PORT_W-1:0]    source_port;
      logic [PORT_W-1:0]    dest_port;
      logic [PKT_SUM_W-1:0] packets_seen;
      logic [LEN_SUM_W-1:0] length_total;
      logic [TTL_SUM_W-1:0] ttl_total;
      logic [PRT_SUM_W-1:0] src_port_total;
      logic [PRT_SUM_W-1:0] dst_port_total;
   } fpst_token_type;

endpackage

// ===== rtl/core/flow_pair_statistics_table.sv =====
// flow pair statistics table
// req channel: one parsed ipv4 header per transaction (addresses, length, ttl,
//   protocol, ports); rsp channel: exactly one transaction per request with the
//   slot of the source, an outcome code on tuser and the slot's updated sums
// the table is a chain of FLOW_SLOTS cells, one flow slot per cell; a header
//   enters an ingress register, then moves one cell per cycle while rsp is not
//   stalled; the first cell that matches its source (or the first empty cell)
//   resolves it; on its way to rsp a request passes the ingress register, each
//   cell in turn and then the output register
// throughput: one transaction per cycle while rsp is not stalled; headers
//   follow each other one cell apart, so later ones always see earlier updates
// a header that passes every cell unresolved reports table full with zeros
// rsp stall: the whole chain, the ingress register and req_tready hold while
//   a result sits unaccepted in the output register
// reset: empties every slot and drops any transaction in flight
module flow_pair_statistics_table
   import fpst_pkg::*;
#(
   parameter int FLOW_SLOTS = FLOW_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // source_address, dest_address, total_length, time_to_live,
   // protocol_number, source_port, dest_port
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // slot_index, packets_seen, length_total, ttl_total, src_port_total,
   // dst_port_total, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // outcome
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   logic                  advance;
   logic                  is_tcp;
   fpst_token_type        req_tok;

   // chain links: entry 0 is the ingress register, entry k+1 is cell k
   logic                  chain_valid [FLOW_SLOTS+1];
   fpst_token_type        chain_tok   [FLOW_SLOTS+1];

   logic                  ingress_valid_ff, ingress_valid_in;
   fpst_token_type        ingress_tok_ff, ingress_tok_in;

   fpst_token_type        last_tok;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   // chain moves whenever the output register is free or being emptied
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // unpack the request; ports count only for tcp
   assign is_tcp = (req_tdata[95:88] == TCP_PROTOCOL);

   always_comb begin
      req_tok                = '0;
      req_tok.source_address = req_tdata[31:0];
      req_tok.dest_address   = req_tdata[63:32];
      req_tok.total_length   = req_tdata[79:64];
      req_tok.time_to_live   = req_tdata[87:80];
      req_tok.source_port    = is_tcp ? req_tdata[111:96] : '0;
      req_tok.dest_port      = is_tcp ? req_tdata[127:112] : '0;
      req_tok.outcome        = OUTCOME_FULL;
   end

   always_comb begin
      ingress_valid_in = ingress_valid_ff;
      ingress_tok_in   = ingress_tok_ff;
      if (advance) begin
         ingress_valid_in = req_tvalid;
         ingress_tok_in   = req_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ingress_valid_ff <= 1'b0;
      end else begin
         ingress_valid_ff <= ingress_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ingress_tok_ff <= ingress_tok_in;
   end

   assign chain_valid[0] = ingress_valid_ff;
   assign chain_tok[0]   = ingress_tok_ff;

   // one cell per flow slot
   for (genvar k = 0; k < FLOW_SLOTS; k++) begin : g_cell
      fpst_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[k]),
         .in_tok    (chain_tok[k]),
         .out_valid (chain_valid[k+1]),
         .out_tok   (chain_tok[k+1])
      );
   end

   assign last_tok = chain_tok[FLOW_SLOTS];

   // output register; an unresolved header means the table is full
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (advance) begin
         rsp_valid_in = chain_valid[FLOW_SLOTS];
         if (last_tok.done) begin
            rsp_data_in = {2'b00, last_tok.dst_port_total, last_tok.src_port_total,
                           last_tok.ttl_total, last_tok.length_total,
                           last_tok.packets_seen, last_tok.slot_index};
            rsp_user_in = last_tok.outcome;
         end else begin
            rsp_data_in = '0;
            rsp_user_in = OUTCOME_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== rtl/core/fpst_cell.sv =====
module fpst_cell
   import fpst_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           in_valid,
   input  fpst_token_type in_tok,
   output logic           out_valid,
   output fpst_token_type out_tok
);

   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_INDEX);

   logic                 valid_ff, valid_in;
   logic [ADDR_W-1:0]    src_ff, src_in;
   logic [ADDR_W-1:0]    dst_ff, dst_in;
   logic [PKT_SUM_W-1:0] pkt_ff, pkt_in;
   logic [LEN_SUM_W-1:0] len_ff, len_in;
   logic [TTL_SUM_W-1:0] ttl_ff, ttl_in;
   logic [PRT_SUM_W-1:0] sp_ff, sp_in;
   logic [PRT_SUM_W-1:0] dp_ff, dp_in;
   logic                 tok_valid_ff, tok_valid_in;
   fpst_token_type       tok_ff, tok_in;

   logic                 claim, src_hit, count;
   logic [PKT_SUM_W:0]   pkt_add;
   logic [LEN_SUM_W:0]   len_add;
   logic [TTL_SUM_W:0]   ttl_add;
   logic [PRT_SUM_W:0]   sp_add;
   logic [PRT_SUM_W:0]   dp_add;
   logic [PKT_SUM_W-1:0] pkt_sat;
   logic [LEN_SUM_W-1:0] len_sat;
   logic [TTL_SUM_W-1:0] ttl_sat;
   logic [PRT_SUM_W-1:0] sp_sat;
   logic [PRT_SUM_W-1:0] dp_sat;

   // slots fill in order, so the first empty cell is the next free slot
   assign claim   = in_valid && !in_tok.done && !valid_ff;
   assign src_hit = in_valid && !in_tok.done && valid_ff && (src_ff == in_tok.source_address);
   assign count   = src_hit && (dst_ff == in_tok.dest_address);

   // saturating sums
   assign pkt_add = {1'b0, pkt_ff} + (PKT_SUM_W+1)'(1);
   assign len_add = {1'b0, len_ff} + (LEN_SUM_W+1)'(in_tok.total_length);
   assign ttl_add = {1'b0, ttl_ff} + (TTL_SUM_W+1)'(in_tok.time_to_live);
   assign sp_add  = {1'b0, sp_ff} + (PRT_SUM_W+1)'(in_tok.source_port);
   assign dp_add  = {1'b0, dp_ff} + (PRT_SUM_W+1)'(in_tok.dest_port);
   assign pkt_sat = pkt_add[PKT_SUM_W] ? '1 : pkt_add[PKT_SUM_W-1:0];
   assign len_sat = len_add[LEN_SUM_W] ? '1 : len_add[LEN_SUM_W-1:0];
   assign ttl_sat = ttl_add[TTL_SUM_W] ? '1 : ttl_add[TTL_SUM_W-1:0];
   assign sp_sat  = sp_add[PRT_SUM_W] ? '1 : sp_add[PRT_SUM_W-1:0];
   assign dp_sat  = dp_add[PRT_SUM_W] ? '1 : dp_add[PRT_SUM_W-1:0];

   always_comb begin
      valid_in     = valid_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      pkt_in       = pkt_ff;
      len_in       = len_ff;
      ttl_in       = ttl_ff;
      sp_in        = sp_ff;
      dp_in        = dp_ff;
      tok_valid_in = tok_valid_ff;
      tok_in       = tok_ff;
      if (advance) begin
         tok_valid_in = in_valid;
         tok_in       = in_tok;
         if (claim) begin
            valid_in = 1'b1;
            src_in   = in_tok.source_address;
            dst_in   = in_tok.dest_address;
            pkt_in   = PKT_SUM_W'(1);
            len_in   = LEN_SUM_W'(in_tok.total_length);
            ttl_in   = TTL_SUM_W'(in_tok.time_to_live);
            sp_in    = PRT_SUM_W'(in_tok.source_port);
            dp_in    = PRT_SUM_W'(in_tok.dest_port);
            tok_in.outcome = OUTCOME_NEW;
         end else if (count) begin
            pkt_in = pkt_sat;
            len_in = len_sat;
            ttl_in = ttl_sat;
            sp_in  = sp_sat;
            dp_in  = dp_sat;
            tok_in.outcome = OUTCOME_HIT;
         end else begin
            tok_in.outcome = src_hit ? OUTCOME_OTHER : in_tok.outcome;
         end
         if (claim || src_hit) begin
            tok_in.done           = 1'b1;
            tok_in.slot_index     = MY_SLOT;
            tok_in.packets_seen   = pkt_in;
            tok_in.length_total   = len_in;
            tok_in.ttl_total      = ttl_in;
            tok_in.src_port_total = sp_in;
            tok_in.dst_port_total = dp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      dst_ff <= dst_in;
      pkt_ff <= pkt_in;
      len_ff <= len_in;
      ttl_ff <= ttl_in;
      sp_ff  <= sp_in;
      dp_ff  <= dp_in;
      tok_ff <= tok_in;
   end

   assign out_valid = tok_valid_ff;
   assign out_tok   = tok_ff;

endmodule
